/* sv/aoc_pkg.sv */
// Shared constants and types for the ARGB over compositor.
package aoc_pkg;

  // Colour channels per pixel (blue, green, red from the low byte up)
  localparam int unsigned NumCh       = 3;
  localparam int unsigned ChW         = 8;
  localparam int unsigned NumW        = 2 * ChW;
  localparam int unsigned PixW        = 32;

  // Pipeline depth: three front stages, then the divider stages
  localparam int unsigned FrontStages = 3;
  localparam int unsigned DivBits     = 2;
  localparam int unsigned DivStages   = ChW / DivBits;
  localparam int unsigned NumStages   = FrontStages + DivStages;

  localparam logic [ChW-1:0]  ByteMax   = 8'hFF;
  localparam logic [PixW-1:0] AlphaMask = 32'hFF00_0000;

  typedef logic [ChW-1:0]  chan_t;
  typedef logic [NumW-1:0] num_t;
  typedef logic [PixW-1:0] pix_t;

  // Sideband that travels with each pixel through the divider
  typedef struct packed {
    logic  pass;   // full or zero coverage: pixel is the finished result
    pix_t  pixel;
    chan_t outa;
  } side_t;

  typedef logic [FrontStages-1:0] front_en_t;
  typedef logic [DivStages-1:0]   div_en_t;

endpackage

/* sv/argb_over_compositor.sv */
// Straight-alpha ARGB8888 over compositor, top level.
// Takes one pixel per clock while s_axis_tready is high and returns results in
// stream order. Each pixel passes seven register stages, the first loaded at the
// transfer edge, made of three alpha and numerator stages and four divider
// stages resolving two quotient bits each. Every stage may hold on its own, so
// bubbles close up and a stalled output still lets new pixels enter until the
// pipeline is full.
module argb_over_compositor
  import aoc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // foreground_pixel, background_pixel, coverage
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // result_pixel
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  num_t  num   [NumCh];
  side_t side3;
  chan_t quot  [NumCh];
  side_t side_out;

  // Stage enables: a stage loads when empty or when its successor moves
  assign en[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
  for (genvar s = 0; s < NumStages - 1; s++) begin : g_en
    assign en[s] = !valid_q[s] || en[s+1];
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  aoc_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[FrontStages-1:0]),
    .fg_i   (s_axis_tdata[PixW-1:0]),
    .bg_i   (s_axis_tdata[2*PixW-1:PixW]),
    .cov_i  (s_axis_tdata[2*PixW +: ChW]),
    .num_o  (num),
    .side_o (side3)
  );

  aoc_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[NumStages-1:FrontStages]),
    .num_i  (num),
    .side_i (side3),
    .quot_o (quot),
    .side_o (side_out)
  );

  // Select finished pixel for the transfer out
  assign m_axis_tvalid = valid_q[NumStages-1];
  assign m_axis_tdata  = side_out.pass ? side_out.pixel
                                       : {side_out.outa, quot[2], quot[1], quot[0]};

endmodule

/* sv/aoc_front.sv */
// Front stages: scaled background alpha, output alpha and channel numerators.
module aoc_front
  import aoc_pkg::*;
(
  input  logic      clk_i,
  input  front_en_t en_i,
  input  pix_t      fg_i,
  input  pix_t      bg_i,
  input  chan_t     cov_i,
  output num_t      num_o [NumCh],
  output side_t     side_o
);

  // Stage 1 registers
  num_t  p1_q;
  chan_t cov1_q;
  chan_t fg1_q [NumCh];
  chan_t bg1_q [NumCh];
  logic  pass1_q;
  pix_t  pix1_q;

  // Stage 2 registers
  chan_t sa2_q;
  chan_t outa2_q;
  chan_t cov2_q;
  chan_t fg2_q [NumCh];
  chan_t bg2_q [NumCh];
  logic  pass2_q;
  pix_t  pix2_q;

  // Stage 3 registers
  num_t  num3_q [NumCh];
  side_t side3_q;

  logic [NumW:0] sa_sum;
  chan_t         sa_d;
  logic [ChW:0]  outa_sum;

  // Stage 1: background alpha times inverse coverage, special cases
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q    <= num_t'(bg_i[PixW-1 -: ChW]) * num_t'(ByteMax - cov_i);
      cov1_q  <= cov_i;
      pass1_q <= (cov_i == ByteMax) || (cov_i == '0);
      pix1_q  <= (cov_i == ByteMax) ? (fg_i | AlphaMask) : bg_i;
      for (int c = 0; c < NumCh; c++) begin
        fg1_q[c] <= fg_i[c*ChW +: ChW];
        bg1_q[c] <= bg_i[c*ChW +: ChW];
      end
    end
  end

  // Divide by 255: exact for 16-bit products
  always_comb begin
    sa_sum   = {1'b0, p1_q} + {{ChW{1'b0}}, 1'b0, p1_q[NumW-1 -: ChW]} + 17'd1;
    sa_d     = sa_sum[NumW-1 -: ChW];
    outa_sum = {1'b0, cov1_q} + {1'b0, sa_d};
  end

  // Stage 2: scaled background alpha and output alpha
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sa2_q   <= sa_d;
      outa2_q <= outa_sum[ChW-1:0];
      cov2_q  <= cov1_q;
      pass2_q <= pass1_q;
      pix2_q  <= pix1_q;
      fg2_q   <= fg1_q;
      bg2_q   <= bg1_q;
    end
  end

  // Stage 3: weighted channel sums
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int c = 0; c < NumCh; c++) begin
        num3_q[c] <= (num_t'(fg2_q[c]) * num_t'(cov2_q))
                   + (num_t'(bg2_q[c]) * num_t'(sa2_q));
      end
      side3_q.pass  <= pass2_q;
      side3_q.pixel <= pix2_q;
      side3_q.outa  <= outa2_q;
    end
  end

  assign num_o  = num3_q;
  assign side_o = side3_q;

endmodule

/* sv/aoc_div.sv */
// Pipelined restoring divider: channel sums over output alpha, two bits a stage.
module aoc_div
  import aoc_pkg::*;
(
  input  logic    clk_i,
  input  div_en_t en_i,
  input  num_t    num_i [NumCh],
  input  side_t   side_i,
  output chan_t   quot_o [NumCh],
  output side_t   side_o
);

  num_t  rem_q  [DivStages][NumCh];
  chan_t quot_q [DivStages][NumCh];
  side_t side_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    num_t  rem_in  [NumCh];
    chan_t quot_in [NumCh];
    side_t side_in;
    num_t  rem_d   [NumCh];
    chan_t quot_d  [NumCh];

    // Select stage input
    if (s == 0) begin : g_first
      always_comb begin
        rem_in  = num_i;
        side_in = side_i;
        for (int c = 0; c < NumCh; c++) begin
          quot_in[c] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        rem_in  = rem_q[s-1];
        quot_in = quot_q[s-1];
        side_in = side_q[s-1];
      end
    end

    // Resolve two quotient bits per channel, most significant first
    always_comb begin
      num_t rem;
      num_t dsh;
      chan_t q;
      for (int c = 0; c < NumCh; c++) begin
        rem = rem_in[c];
        q   = quot_in[c];
        for (int b = DivBits - 1; b >= 0; b--) begin
          dsh = num_t'({{ChW{1'b0}}, side_in.outa}
                << (ChW - DivBits * (s + 1) + b));
          q = {q[ChW-2:0], 1'b0};
          if (rem >= dsh) begin
            rem  = rem - dsh;
            q[0] = 1'b1;
          end
        end
        rem_d[c]  = rem;
        quot_d[c] = q;
      end
    end

    // Advance stage
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_d;
        quot_q[s] <= quot_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign quot_o = quot_q[DivStages-1];
  assign side_o = side_q[DivStages-1];

endmodule

/* sv/aoc_checker.sv */
// Port checker for the compositor, bound to the top level.
module aoc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // An empty output stage means the pipeline can take a transfer
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A taken result frees the whole pipeline
  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // A result cannot appear from an idle input as reset is released
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result without a transfer in");

endmodule

bind argb_over_compositor aoc_checker u_aoc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/argb_over_compositor_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ARGB over compositor: directed and random pixel streams.
module argb_over_compositor_test;
  import aoc_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned IdlePct    = 28;

  // Predict composited pixels and match them against the output stream in order
  class over_scoreboard;
    pix_t        expected_pixels[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // Straight-alpha over: scale the background alpha by the inverse coverage
    function pix_t blend_over(pix_t fg, pix_t bg, chan_t cov);
      int unsigned bg_alpha;
      int unsigned scaled_alpha;
      int unsigned out_alpha;
      int unsigned weighted;
      pix_t        blended;
      if (cov == ByteMax) return fg | AlphaMask;
      if (cov == '0) return bg;
      bg_alpha     = int'(bg[31:24]);
      scaled_alpha = bg_alpha * (int'(ByteMax) - int'(cov)) / int'(ByteMax);
      out_alpha    = int'(cov) + scaled_alpha;
      if (out_alpha == 0) return '0;
      blended        = '0;
      blended[31:24] = out_alpha[7:0];
      for (int ch = 0; ch < NumCh; ch++) begin
        weighted = int'(fg[ch*ChW +: ChW]) * int'(cov)
                 + int'(bg[ch*ChW +: ChW]) * scaled_alpha;
        blended[ch*ChW +: ChW] = chan_t'(weighted / out_alpha);
      end
      return blended;
    endfunction

    function void note_pixel_in(pix_t fg, pix_t bg, chan_t cov);
      expected_pixels.push_back(blend_over(fg, bg, cov));
    endfunction

    function void check_pixel_out(pix_t got);
      pix_t want;
      if (expected_pixels.size() == 0) begin
        $error("result_pixel: expected none, actual %h", got);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want) begin
        $error("result_pixel: expected %h, actual %h", want, got);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;  // foreground_pixel, background_pixel, coverage
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // result_pixel

  logic           idle_on      = 1'b1;
  int unsigned    quiet_cycles = 0;
  over_scoreboard sb;

  argb_over_compositor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one pixel, with random gaps ahead of it while idling is on, and hold it until the transfer
  task automatic send_pixel(input pix_t fg, input pix_t bg, input chan_t cov);
    while (idle_on && ($urandom_range(99) < IdlePct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cov, bg, fg};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel_in(fg, bg, cov);
  endtask

  // Bias coverage towards the opaque, transparent and near-edge cases
  task automatic send_random_pixel();
    pix_t  fg;
    pix_t  bg;
    chan_t cov;
    fg = $urandom;
    bg = $urandom;
    case ($urandom_range(9))
      0:       cov = '0;
      1:       cov = ByteMax;
      2:       cov = $urandom_range(1) ? chan_t'(1) : chan_t'(ByteMax - 1);
      default: cov = chan_t'($urandom_range(255));
    endcase
    case ($urandom_range(9))
      0:       bg[31:24] = '0;
      1:       bg[31:24] = ByteMax;
      default: ;
    endcase
    send_pixel(fg, bg, cov);
  endtask

  // Hold the input back until every predicted pixel has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Output side: stall at random unless idling is switched off
  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(99) >= IdlePct);
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_pixel_out(m_axis_tdata);
  end

  // Watchdog: give up when nothing moves for too long
  initial begin
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("argb_over_compositor_test: FAIL");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: coverage extremes, alpha byte ignored, transparent background
    send_pixel(32'h0000_0000, 32'h0000_0000, 8'd0);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    send_pixel(32'h1234_5678, 32'h89AB_CDEF, 8'd0);
    send_pixel(32'h1234_5678, 32'h89AB_CDEF, ByteMax);
    send_pixel(32'h00AB_CDEF, 32'hFFFF_FFFF, ByteMax);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, ByteMax);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF, ByteMax);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 8'd1);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 8'd1);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 8'd254);
    send_pixel(32'hFFFF_FFFF, 32'hFF00_0000, 8'd254);
    send_pixel(32'h0011_2233, 32'h00FF_FFFF, 8'd128);
    send_pixel(32'hFF11_2233, 32'h00FF_FFFF, 8'd128);
    send_pixel(32'h00FF_00FF, 32'h0000_FF00, 8'd1);
    send_pixel(32'hAA80_4020, 32'hFF10_2040, 8'd128);
    send_pixel(32'h5500_FF00, 32'h80FF_00FF, 8'd127);
    send_pixel(32'h0000_0000, 32'h0100_0000, 8'd200);
    send_pixel(32'hFFFF_FFFF, 32'h7F7F_7F7F, 8'd64);
    wait_drained();

    // Random: idling on, then a stretch with both sides flat out, then idling again
    repeat (600) send_random_pixel();
    wait_drained();
    idle_on <= 1'b0;
    repeat (400) send_random_pixel();
    idle_on <= 1'b1;
    repeat (650) send_random_pixel();

    // Drain and let the pipeline settle
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (NumStages + 4) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("argb_over_compositor_test: PASS");
    end else begin
      $display("argb_over_compositor_test: FAIL");
    end
    $finish;
  end

endmodule
